FILE: design/tdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC fine-time calibrator package
// Shared widths, controller states and command/status structs.
// ----------------------------------------------------------------------------
package tdc_pkg;

    localparam int CODE_BITS     = 10;
    localparam int COUNT_BITS    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int NCODES        = 1 << CODE_BITS;
    localparam int HIST_ABITS    = CODE_BITS + 1;
    localparam int FDIV_BITS     = $clog2(FRACTION_BITS + 1);
    localparam int CFG_BITS      = 21;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] REG_INIT_RECAL = 2'd0;
    localparam logic [1:0] REG_MIN_SWAP   = 2'd1;
    localparam logic [1:0] REG_INVALID    = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_BUILD,
        ST_BUILD_LAST,
        ST_DECIDE_A,
        ST_DECIDE_B,
        ST_WIPE,
        ST_COUNT_RD,
        ST_COUNT_WR,
        ST_LOOKUP,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic latch_code;
        logic start_build;
        logic build_step;
        logic build_finish;
        logic mult_span;
        logic decide;
        logic wipe_start;
        logic wipe_step;
        logic count_read;
        logic count_write;
        logic lookup;
        logic div_start;
        logic div_step;
        logic out_load;
        logic out_zero;
    } cmd_t;

    typedef struct packed {
        logic invalid;
        logic need_recal;
        logic build_done;
        logic wipe_done;
        logic clear_done;
        logic table_valid;
        logic div_done;
    } status_t;

endpackage

FILE: design/tdc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC calibrator controller
// Sequences clearing, table rebuild, bin update and the fraction divide.
// ----------------------------------------------------------------------------
module tdc_ctrl
    import tdc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    out_busy,
    output cmd_t    cmd,
    input  status_t sts
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:      if (sts.clear_done) state_next = ST_IDLE;
            ST_IDLE:       if (in_valid) state_next = ST_CHECK;
            ST_CHECK:
                if (sts.invalid) state_next = ST_OUTPUT;
                else if (sts.need_recal) state_next = ST_BUILD;
                else state_next = ST_COUNT_RD;
            ST_BUILD:      if (sts.build_done) state_next = ST_BUILD_LAST;
            ST_BUILD_LAST: state_next = ST_DECIDE_A;
            ST_DECIDE_A:   state_next = ST_DECIDE_B;
            ST_DECIDE_B:   state_next = ST_WIPE;
            ST_WIPE:       if (sts.wipe_done) state_next = ST_COUNT_RD;
            ST_COUNT_RD:   state_next = ST_COUNT_WR;
            ST_COUNT_WR:   state_next = sts.table_valid ? ST_LOOKUP : ST_OUTPUT;
            ST_LOOKUP:     state_next = ST_DIVIDE;
            ST_DIVIDE:     if (sts.div_done) state_next = ST_OUTPUT;
            ST_OUTPUT:     if (!out_busy) state_next = ST_IDLE;
            default:       state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:      cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.latch_code = in_valid;
            end
            ST_CHECK:
            begin
                cmd.start_build = !sts.invalid && sts.need_recal;
                cmd.out_zero    = sts.invalid;
            end
            ST_BUILD:      cmd.build_step = 1'b1;
            ST_BUILD_LAST: cmd.build_finish = 1'b1;
            ST_DECIDE_A:   cmd.mult_span = 1'b1;
            ST_DECIDE_B:
            begin
                cmd.decide     = 1'b1;
                cmd.wipe_start = 1'b1;
            end
            ST_WIPE:       cmd.wipe_step = 1'b1;
            ST_COUNT_RD:   cmd.count_read = 1'b1;
            ST_COUNT_WR:
            begin
                cmd.count_write = 1'b1;
                cmd.out_zero    = !sts.table_valid;
            end
            ST_LOOKUP:
            begin
                cmd.lookup    = 1'b1;
                cmd.div_start = 1'b1;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cmd.out_load = sts.div_done;
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUILD) |-> in_stall)
        else $error("input taken during rebuild");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch_code |=> (state_reg == ST_CHECK))
        else $error("request not checked");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUTPUT && out_busy) |=> (state_reg == ST_OUTPUT))
        else $error("result left while stalled");

endmodule

FILE: design/tdc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC calibrator datapath
// Histogram memory, cumulative table memory, span registers and divider.
// ----------------------------------------------------------------------------
module tdc_datapath
    import tdc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_BITS-1:0]      cfg_data,
    input  logic [CODE_BITS-1:0]     fine_code,
    input  cmd_t                     cmd,
    output status_t                  sts,
    output logic [FRACTION_BITS-1:0] frac_result
);

    logic [20:0]            min_swap_reg;
    logic [CODE_BITS-1:0]   invalid_reg;

    logic [COUNT_BITS-1:0]  hist_mem [0:2*NCODES-1];
    logic [COUNT_BITS-1:0]  cum_mem  [0:NCODES-1];
    logic [COUNT_BITS-1:0]  hist_rd_reg;
    logic [COUNT_BITS-1:0]  cum_rd_reg;

    logic [COUNT_BITS-1:0]  span_count_reg [2];
    logic [CODE_BITS-1:0]   span_low_reg [2];
    logic [CODE_BITS-1:0]   span_high_reg [2];
    logic                   span_empty_reg [2];
    logic                   active_reg;
    logic [CODE_BITS-1:0]   table_top_reg;
    logic [COUNT_BITS-1:0]  table_total_reg;
    logic                   table_valid_reg;
    logic [COUNT_BITS-1:0]  threshold_reg;

    logic [CODE_BITS-1:0]   code_reg;
    logic [CODE_BITS:0]     sweep_reg;
    logic [CODE_BITS-1:0]   build_idx_reg;
    logic                   build_rd_reg;
    logic [COUNT_BITS-1:0]  acc_reg;
    logic [31:0]            want_reg;

    logic [COUNT_BITS-1:0]  rem_reg;
    logic [COUNT_BITS-1:0]  den_reg;
    logic [FRACTION_BITS-1:0] quo_reg;
    logic [FDIV_BITS-1:0]   div_cnt_reg;

    logic [CODE_BITS:0]     width_v;
    logic [31:0]            width32;
    logic [COUNT_BITS:0]    acc_sum;
    logic [COUNT_BITS:0]    rem_sh;
    logic [COUNT_BITS:0]    inc_sum;
    logic [COUNT_BITS:0]    cnt_sum;
    logic [COUNT_BITS+2:0]  want7;
    logic [CODE_BITS-1:0]   lookup_idx;
    logic                   s;

    assign s = active_reg;
    assign width_v = {1'b0, span_high_reg[s]} - {1'b0, span_low_reg[s]} + 1'b1;
    assign width32 = 32'(width_v);
    assign acc_sum = {1'b0, acc_reg} + {1'b0, hist_rd_reg};
    assign rem_sh  = {rem_reg, 1'b0};
    assign inc_sum = {1'b0, hist_rd_reg} + 1'b1;
    assign cnt_sum = {1'b0, span_count_reg[s]} + 1'b1;
    assign want7   = 35'(want_reg) * 35'd7;
    assign lookup_idx = (code_reg < table_top_reg) ? code_reg : table_top_reg;

    assign sts.invalid     = (code_reg == invalid_reg);
    assign sts.need_recal  = (span_count_reg[s] >= threshold_reg);
    assign sts.build_done  = build_rd_reg && (build_idx_reg == table_top_reg);
    assign sts.wipe_done   = sweep_reg[CODE_BITS];
    assign sts.clear_done  = (sweep_reg == (CODE_BITS+1)'(NCODES - 1)) && !cmd.wipe_step;
    assign sts.table_valid = table_valid_reg;
    assign sts.div_done    = (div_cnt_reg == FDIV_BITS'(FRACTION_BITS));

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            hist_mem[{1'b0, sweep_reg[CODE_BITS-1:0]}] <= '0;
            hist_mem[{1'b1, sweep_reg[CODE_BITS-1:0]}] <= '0;
        end
        else if (cmd.wipe_step && !sweep_reg[CODE_BITS])
            hist_mem[{s, sweep_reg[CODE_BITS-1:0]}] <= '0;
        else if (cmd.count_write)
            hist_mem[{s, code_reg}] <= inc_sum[COUNT_BITS] ? COUNT_MAX :
                                       inc_sum[COUNT_BITS-1:0];
        if (cmd.start_build)
            hist_rd_reg <= hist_mem[{s, {CODE_BITS{1'b0}}}];
        else if (cmd.build_step)
            hist_rd_reg <= hist_mem[{s, build_idx_reg + 1'b1}];
        else if (cmd.count_read)
            hist_rd_reg <= hist_mem[{s, code_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.build_step && build_rd_reg)
            cum_mem[build_idx_reg] <= acc_reg;
        if (cmd.lookup)
            cum_rd_reg <= cum_mem[lookup_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_code)
            code_reg <= fine_code;
        if (cmd.start_build)
            acc_reg <= '0;
        else if (cmd.build_step && build_rd_reg)
            acc_reg <= acc_sum[COUNT_BITS] ? COUNT_MAX : acc_sum[COUNT_BITS-1:0];
        if (cmd.mult_span)
            want_reg <= width32 * width32;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_swap_reg      <= 21'd1000;
            invalid_reg       <= {CODE_BITS{1'b1}};
            threshold_reg     <= COUNT_BITS'(10);
            span_count_reg[0] <= '0;
            span_count_reg[1] <= '0;
            span_low_reg[0]   <= '0;
            span_low_reg[1]   <= '0;
            span_high_reg[0]  <= '0;
            span_high_reg[1]  <= '0;
            span_empty_reg[0] <= 1'b1;
            span_empty_reg[1] <= 1'b1;
            active_reg        <= 1'b0;
            table_top_reg     <= '0;
            table_total_reg   <= '0;
            table_valid_reg   <= 1'b0;
            sweep_reg         <= '0;
            build_idx_reg     <= '0;
            build_rd_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INIT_RECAL: threshold_reg <= COUNT_BITS'(cfg_data[15:0]);
                    REG_MIN_SWAP:   min_swap_reg  <= cfg_data[20:0];
                    REG_INVALID:    invalid_reg   <= cfg_data[CODE_BITS-1:0];
                    default: ;
                endcase
            end
            if (cmd.clear_step)
                sweep_reg <= sweep_reg + 1'b1;
            if (cmd.start_build)
            begin
                table_top_reg <= span_empty_reg[s] ? '0 : span_high_reg[s];
                build_idx_reg <= '0;
                build_rd_reg  <= 1'b1;
            end
            else if (cmd.build_step && !sts.build_done)
                build_idx_reg <= build_idx_reg + 1'b1;
            if (cmd.build_finish)
            begin
                table_total_reg <= acc_reg;
                table_valid_reg <= 1'b1;
                build_rd_reg    <= 1'b0;
            end
            if (cmd.decide)
            begin
                if (span_count_reg[s] > COUNT_BITS'(min_swap_reg) &&
                    span_count_reg[s] > COUNT_BITS'(want7 >> 3))
                begin
                    threshold_reg      <= COUNT_BITS'(want_reg);
                    active_reg         <= !s;
                    span_count_reg[!s] <= '0;
                    span_empty_reg[!s] <= 1'b1;
                    sweep_reg          <= '0;
                end
                else
                begin
                    threshold_reg <= threshold_reg[COUNT_BITS-1] ? COUNT_MAX :
                                     {threshold_reg[COUNT_BITS-2:0], 1'b0};
                    sweep_reg     <= {1'b1, {CODE_BITS{1'b0}}};
                end
            end
            else if (cmd.wipe_step && !sweep_reg[CODE_BITS])
                sweep_reg <= sweep_reg + 1'b1;
            if (cmd.count_write)
            begin
                span_count_reg[s] <= cnt_sum[COUNT_BITS] ? COUNT_MAX :
                                     cnt_sum[COUNT_BITS-1:0];
                if (span_empty_reg[s])
                begin
                    span_low_reg[s]   <= code_reg;
                    span_high_reg[s]  <= code_reg;
                    span_empty_reg[s] <= 1'b0;
                end
                else
                begin
                    if (code_reg < span_low_reg[s])  span_low_reg[s]  <= code_reg;
                    if (code_reg > span_high_reg[s]) span_high_reg[s] <= code_reg;
                end
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            div_cnt_reg <= '0;
        else if (cmd.div_step && !sts.div_done)
        begin
            if (div_cnt_reg == '0)
            begin
                den_reg <= table_total_reg;
                if (table_total_reg == '0)
                begin
                    rem_reg     <= cum_rd_reg;
                    quo_reg     <= '0;
                    div_cnt_reg <= FDIV_BITS'(FRACTION_BITS);
                end
                else if (cum_rd_reg >= table_total_reg)
                begin
                    rem_reg     <= cum_rd_reg;
                    quo_reg     <= '1;
                    div_cnt_reg <= FDIV_BITS'(FRACTION_BITS);
                end
                else
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    rem_reg <= ({cum_rd_reg, 1'b0} >= {1'b0, table_total_reg}) ?
                               COUNT_BITS'({cum_rd_reg, 1'b0} - {1'b0, table_total_reg}) :
                               {cum_rd_reg[COUNT_BITS-2:0], 1'b0};
                    quo_reg <= FRACTION_BITS'(
                               {cum_rd_reg, 1'b0} >= {1'b0, table_total_reg});
                end
            end
            else
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                rem_reg <= (rem_sh >= {1'b0, den_reg}) ?
                           COUNT_BITS'(rem_sh - {1'b0, den_reg}) : rem_sh[COUNT_BITS-1:0];
                quo_reg <= {quo_reg[FRACTION_BITS-2:0], rem_sh >= {1'b0, den_reg}};
            end
        end
    end

    assign frac_result = quo_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.build_finish |=> table_valid_reg)
        else $error("table not marked valid");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.count_write && !span_empty_reg[s]) |-> (span_low_reg[s] <= span_high_reg[s]))
        else $error("span bounds crossed");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |=> (sweep_reg == '0 || sweep_reg[CODE_BITS]))
        else $error("wipe sweep not set up");

endmodule

FILE: design/tdc_fine_time_calibrator.sv
`timescale 1ns / 1ps
// An invalid code, or any code before a table exists, returns an uncalibrated zero;
// with a table up to 16 quotient bits come out, one a cycle. One request at a time:
// a new request is taken only after the last result has left the output register.
// Recalibration adds a prefix sum over the bins up to top and, on a swap, a wipe of
// the new active histogram bank.
// After reset both histogram banks are cleared; input stalls meanwhile.
// ----------------------------------------------------------------------------
// TDC fine-time calibrator
// Code-density calibration of raw fine codes to a fraction of one period.
// ----------------------------------------------------------------------------
module tdc_fine_time_calibrator
    import tdc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_BITS-1:0]      cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CODE_BITS-1:0]     fine_code,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [FRACTION_BITS-1:0] fraction,
    output logic                     calibrated
);

    cmd_t    cmd;
    status_t sts;
    logic [FRACTION_BITS-1:0] frac_result;
    logic    busy;

    assign busy = out_valid && out_stall;

    tdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_busy (busy),
        .cmd      (cmd),
        .sts      (sts)
    );

    tdc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fine_code   (fine_code),
        .cmd         (cmd),
        .sts         (sts),
        .frac_result (frac_result)
    );

    // the controller stays in output until the register is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.out_zero || cmd.out_load)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_zero)
        begin
            fraction   <= '0;
            calibrated <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            fraction   <= frac_result;
            calibrated <= 1'b1;
        end
    end

endmodule

FILE: dv/tb_tdc_fine_time_calibrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC fine-time calibrator testbench
// Drives fine codes through bursts and gaps under a random output stall,
// predicts each calibrated fraction from a code-density model kept in a
// scoreboard, and steps through register settings between traffic phases.
// ----------------------------------------------------------------------------
module tb_tdc_fine_time_calibrator;
    import tdc_pkg::*;

    typedef struct {
        logic [FRACTION_BITS-1:0] fraction;
        logic                     calibrated;
    } fine_result_t;

    class fine_time_scoreboard;
        longint unsigned hist[2][NCODES];
        longint unsigned span_count[2];
        longint unsigned span_low[2];
        longint unsigned span_high[2];
        longint unsigned cum_table[NCODES];
        longint unsigned table_top;
        longint unsigned table_total;
        longint unsigned recal_threshold;
        longint unsigned init_recal;
        longint unsigned min_swap;
        longint unsigned invalid_code;
        bit              active;
        bit              table_valid;
        fine_result_t    pending_results[$];
        int              errors;

        function new();
            init_recal = 10;
            min_swap = 1000;
            invalid_code = NCODES - 1;
            recal_threshold = init_recal;
            clear_bank(0);
            clear_bank(1);
            active = 0;
            table_valid = 0;
            table_top = 0;
            table_total = 0;
            errors = 0;
        endfunction

        function longint unsigned sat_add(longint unsigned a, longint unsigned b);
            longint unsigned s;
            s = a + b;
            return (s > COUNT_MAX) ? COUNT_MAX : s;
        endfunction

        function void clear_bank(bit b);
            for (int i = 0; i < NCODES; i++)
                hist[b][i] = 0;
            span_count[b] = 0;
            span_low[b] = 1;
            span_high[b] = 0;
        endfunction

        function void write_reg(logic [1:0] idx, longint unsigned value);
            if (idx == REG_INIT_RECAL) begin
                init_recal = value & 16'hffff;
                recal_threshold = init_recal;
            end else if (idx == REG_MIN_SWAP) begin
                min_swap = value & 21'h1fffff;
            end else if (idx == REG_INVALID) begin
                invalid_code = value & 10'h3ff;
            end
        endfunction

        function longint unsigned fraction_of(longint unsigned num, longint unsigned den);
            longint unsigned q;
            longint unsigned r;
            if (den == 0)
                return 0;
            if (num >= den)
                return (1 << FRACTION_BITS) - 1;
            q = 0;
            r = num;
            for (int k = 0; k < FRACTION_BITS; k++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q = q | 1;
                end
            end
            return q;
        endfunction

        function void note_request(logic [CODE_BITS-1:0] code);
            fine_result_t    res;
            bit              b;
            longint unsigned acc;
            longint unsigned width;
            longint unsigned want;
            longint unsigned idx;
            res.fraction = 0;
            res.calibrated = 0;
            if (code == invalid_code) begin
                pending_results.push_back(res);
                return;
            end
            b = active;
            if (span_count[b] >= recal_threshold) begin
                acc = 0;
                table_top = span_high[b] & (NCODES - 1);
                for (int i = 0; i <= table_top; i++) begin
                    cum_table[i] = acc;
                    acc = sat_add(acc, hist[b][i]);
                end
                table_total = acc;
                table_valid = 1;
                width = (span_high[b] - span_low[b] + 1) & 64'hffffffff;
                want = (width * width) & 64'hffffffff;
                if (span_count[b] > min_swap && span_count[b] > (7 * want) / 8) begin
                    recal_threshold = want;
                    active = !b;
                    b = active;
                    clear_bank(b);
                end else begin
                    recal_threshold = (recal_threshold > COUNT_MAX / 2) ? COUNT_MAX
                                      : recal_threshold * 2;
                end
            end
            if (span_low[b] > span_high[b]) begin
                span_low[b] = code;
                span_high[b] = code;
            end else begin
                if (code < span_low[b])
                    span_low[b] = code;
                if (code > span_high[b])
                    span_high[b] = code;
            end
            hist[b][code] = sat_add(hist[b][code], 1);
            span_count[b] = sat_add(span_count[b], 1);
            if (table_valid) begin
                idx = (code < table_top) ? code : table_top;
                res.fraction = FRACTION_BITS'(fraction_of(cum_table[idx], table_total));
                res.calibrated = 1;
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [FRACTION_BITS-1:0] frac, logic cal);
            fine_result_t want_res;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: fraction %0d", frac);
                errors++;
                return;
            end
            want_res = pending_results.pop_front();
            if (frac !== want_res.fraction) begin
                $error("fraction: expected %0d, actual %0d", want_res.fraction, frac);
                errors++;
            end
            if (cal !== want_res.calibrated) begin
                $error("calibrated: expected %0d, actual %0d", want_res.calibrated, cal);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [1:0]               cfg_index;
    logic [CFG_BITS-1:0]      cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [CODE_BITS-1:0]     fine_code;
    logic                     out_valid;
    logic                     out_stall;
    logic [FRACTION_BITS-1:0] fraction;
    logic                     calibrated;

    fine_time_scoreboard sb;
    int                  burst_left;
    int                  stall_mode;
    int                  stall_timer;

    tdc_fine_time_calibrator dut (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver stall pattern: free, light or heavy, switched at random
    always @(negedge clk)
    begin
        if (stall_timer == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_timer <= $urandom_range(20, 300);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(fraction, calibrated);
    end

    task automatic send_code(logic [CODE_BITS-1:0] code);
        int gap;
        @(negedge clk);
        in_valid = 1'b1;
        fine_code = code;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(code);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                @(negedge clk);
                in_valid = 1'b0;
                fine_code = CODE_BITS'($urandom);
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic drain_and_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_BITS'(value);
        @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // mostly codes from a window of span codes from base, some noise across the full range and some invalid codes
    task automatic send_window(int n, int base, int span, int noise_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_code(CODE_BITS'($urandom));
            else if ($urandom_range(0, 19) == 0)
                send_code(CODE_BITS'(sb.invalid_code));
            else
                send_code(CODE_BITS'((base + $urandom_range(0, span - 1)) % NCODES));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        fine_code = '0;
        out_stall = 1'b0;
        stall_mode = 0;
        stall_timer = 0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero threshold before any traffic: rebuild from an empty bank
        write_reg(REG_INIT_RECAL, 0);
        write_reg(REG_MIN_SWAP, 0);
        write_reg(REG_INVALID, 5);
        send_code(7);
        send_code(5);
        send_code(7);
        send_code(8);
        send_code(0);
        send_code(CODE_BITS'(NCODES - 1));
        send_code(3);
        send_code(9);
        drain_and_idle();

        // defaults, directed extremes then wide random traffic
        write_reg(REG_INIT_RECAL, 10);
        write_reg(REG_MIN_SWAP, 1000);
        write_reg(REG_INVALID, NCODES - 1);
        write_reg(2'd3, 12);
        send_code(0);
        send_code(CODE_BITS'(NCODES - 1));
        send_code(1);
        send_code(512);
        send_code(CODE_BITS'(NCODES - 2));
        send_code(10'h155);
        send_code(10'h2aa);
        for (int i = 0; i < 8; i++)
            send_code(CODE_BITS'($urandom_range(0, 20)));
        send_code(600);
        send_code(CODE_BITS'(NCODES - 2));
        send_code(0);
        send_window(300, 0, NCODES, 0);
        drain_and_idle();

        // narrow window with early swaps
        write_reg(REG_INIT_RECAL, 20);
        write_reg(REG_MIN_SWAP, 30);
        write_reg(REG_INVALID, $urandom_range(0, NCODES - 1));
        send_window(600, $urandom_range(0, NCODES - 1), 8, 3);
        drain_and_idle();

        // large settings: no early rebuild, never a swap
        write_reg(REG_INIT_RECAL, 65535);
        write_reg(REG_MIN_SWAP, 1048576);
        write_reg(REG_INVALID, 0);
        send_window(150, 0, NCODES, 0);
        drain_and_idle();

        // threshold of one, drifting windows
        write_reg(REG_INIT_RECAL, 1);
        write_reg(REG_MIN_SWAP, 0);
        write_reg(REG_INVALID, NCODES - 1);
        for (int p = 0; p < 6; p++)
            send_window(100, $urandom_range(0, NCODES - 1), $urandom_range(1, 24), 5);
        drain_and_idle();

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/tdc_pkg.sv
design/tdc_ctrl.sv
design/tdc_datapath.sv
design/tdc_fine_time_calibrator.sv
dv/tb_tdc_fine_time_calibrator.sv
